[sv/urb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urb_pkg
// Shared types and constants of the uart register block with receive fifo.
// ---------------------------------------------------------------------------
package urb_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // item kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_BREAK = 2'd3;

    localparam logic [3:0] SIZE_BYTE = 4'd1;

    // register offsets
    localparam logic [7:0] ADDR_TXBUF = 8'h00;
    localparam logic [7:0] ADDR_RXBUF = 8'h02;
    localparam logic [7:0] ADDR_ICTRL = 8'h04;
    localparam logic [7:0] ADDR_LSTAT = 8'h06;
    localparam logic [7:0] ADDR_FSEL  = 8'h08;
    localparam logic [7:0] ADDR_MSEL  = 8'h0a;
    localparam logic [7:0] ADDR_BAUD  = 8'h0c;
    localparam logic [7:0] ADDR_PSR   = 8'h0e;
    localparam logic [7:0] ADDR_FCTRL = 8'h16;
    localparam logic [7:0] ADDR_TXLVL = 8'h18;
    localparam logic [7:0] ADDR_RXLVL = 8'h1a;

    // control and status bits
    localparam int CTRL_TBE_BIT = 0;
    localparam int CTRL_RBF_BIT = 1;
    localparam int CTRL_ETI_BIT = 5;
    localparam int CTRL_ERI_BIT = 6;
    localparam int STAT_BREAK_BIT = 4;
    localparam int STAT_XMIP_BIT  = 6;

    // reset values
    localparam logic [7:0] ICTRL_RESET = 8'h01;
    localparam logic [7:0] BAUD_RESET  = 8'h33;
    localparam logic [7:0] PSR_RESET   = 8'h08;

endpackage

[sv/urb_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urb_ram
// Generic single-write, single-read ram with registered read data.
// ---------------------------------------------------------------------------
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/urb_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urb_ctrl
// Sequencer: takes an item, executes it once the result register is free.
// ---------------------------------------------------------------------------
module urb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output urb_pkg::cmd_t  cmd
);

    urb_pkg::state_t state_reg;
    urb_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            urb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = urb_pkg::ST_EXEC;
                end
            end
            urb_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = urb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = urb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            urb_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            urb_pkg::ST_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= urb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == urb_pkg::ST_EXEC) && !in_ready)
        else $error("item accepted but not executed next");

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result executed but not presented");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result overwritten before taken");

endmodule

[sv/urb_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urb_dp
// Register file, receive ring fifo and result registers.
// ---------------------------------------------------------------------------
module urb_dp #(
    parameter int RX_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  urb_pkg::cmd_t cmd,
    input  logic [1:0]    mode,
    input  logic [7:0]    addr,
    input  logic [7:0]    data,
    input  logic [3:0]    access_size,
    output logic [7:0]    read_data,
    output logic          tx_valid,
    output logic [7:0]    tx_byte,
    output logic          irq,
    output logic [4:0]    rx_space,
    output logic          rx_dropped
);

    localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);

    // captured item
    logic [1:0] mode_reg;
    logic [7:0] addr_reg;
    logic [7:0] data_reg;
    logic [3:0] size_reg;

    // register file
    logic [7:0] tx_buffer_reg,    tx_buffer_next;
    logic [7:0] int_control_reg,  int_control_next;
    logic [7:0] line_status_reg,  line_status_next;
    logic [7:0] frame_select_reg, frame_select_next;
    logic [7:0] mode_select_reg,  mode_select_next;
    logic [7:0] baud_divisor_reg, baud_divisor_next;
    logic [7:0] prescaler_reg,    prescaler_next;
    logic [7:0] fifo_control_reg, fifo_control_next;

    // ring pointers
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    // result registers
    logic [7:0] read_data_reg,  read_data_next;
    logic       tx_valid_reg,   tx_valid_next;
    logic [7:0] tx_byte_reg,    tx_byte_next;
    logic       irq_reg,        irq_next;
    logic [4:0] rx_space_reg,   rx_space_next;
    logic       rx_dropped_reg, rx_dropped_next;

    logic [7:0]    ram_rdata;
    logic          push;
    logic          pop;
    logic          is_byte;
    logic          fifo_full;
    logic          fifo_empty;
    logic [7:0]    ctrl_view;
    logic [CW+7:0] count_ext;
    logic [CW-1:0] space_full;
    logic [CW+4:0] space_ext;
    logic [PW:0]   ptr_sum;
    logic [PW:0]   ptr_wrap;

    urb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_store (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (data_reg),
        .re    (cmd.capture),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            addr_reg <= addr;
            data_reg <= data;
            size_reg <= access_size;
        end
    end

    assign is_byte    = (size_reg == urb_pkg::SIZE_BYTE);
    assign fifo_full  = (count_reg == CW'(RX_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign push = cmd.commit && (mode_reg == urb_pkg::MODE_RX) && !fifo_full;
    assign pop  = cmd.commit && (mode_reg == urb_pkg::MODE_READ) && is_byte
                  && (addr_reg == urb_pkg::ADDR_RXBUF) && !fifo_empty;
    assign count_ext = (CW + 8)'(count_reg);

    always_comb
    begin
        ctrl_view = int_control_reg;
        ctrl_view[urb_pkg::CTRL_TBE_BIT] = 1'b1;
        ctrl_view[urb_pkg::CTRL_RBF_BIT] = !fifo_empty;
    end

    // bus read decode
    always_comb
    begin
        read_data_next = '0;
        if (mode_reg == urb_pkg::MODE_READ && is_byte)
        begin
            unique case (addr_reg)
                urb_pkg::ADDR_TXBUF: read_data_next = tx_buffer_reg;
                urb_pkg::ADDR_RXBUF: read_data_next = fifo_empty ? 8'h00 : ram_rdata;
                urb_pkg::ADDR_ICTRL: read_data_next = ctrl_view;
                urb_pkg::ADDR_LSTAT: read_data_next = line_status_reg;
                urb_pkg::ADDR_FSEL:  read_data_next = frame_select_reg;
                urb_pkg::ADDR_MSEL:  read_data_next = mode_select_reg;
                urb_pkg::ADDR_BAUD:  read_data_next = baud_divisor_reg;
                urb_pkg::ADDR_PSR:   read_data_next = prescaler_reg;
                urb_pkg::ADDR_FCTRL: read_data_next = fifo_control_reg;
                urb_pkg::ADDR_TXLVL: read_data_next = 8'h00;
                urb_pkg::ADDR_RXLVL: read_data_next = count_ext[7:0];
                default:             read_data_next = 8'h00;
            endcase
        end
    end

    // register writes, line events
    always_comb
    begin
        tx_buffer_next    = tx_buffer_reg;
        int_control_next  = int_control_reg;
        line_status_next  = line_status_reg;
        frame_select_next = frame_select_reg;
        mode_select_next  = mode_select_reg;
        baud_divisor_next = baud_divisor_reg;
        prescaler_next    = prescaler_reg;
        fifo_control_next = fifo_control_reg;
        tx_valid_next     = 1'b0;
        tx_byte_next      = 8'h00;
        if (cmd.commit)
        begin
            if (mode_reg == urb_pkg::MODE_WRITE && is_byte)
            begin
                unique case (addr_reg)
                    urb_pkg::ADDR_TXBUF:
                    begin
                        tx_buffer_next = data_reg;
                        tx_valid_next  = 1'b1;
                        tx_byte_next   = data_reg;
                        line_status_next[urb_pkg::STAT_XMIP_BIT] = 1'b0;
                    end
                    urb_pkg::ADDR_ICTRL: int_control_next  = data_reg;
                    urb_pkg::ADDR_LSTAT: line_status_next  = data_reg;
                    urb_pkg::ADDR_FSEL:  frame_select_next = data_reg;
                    urb_pkg::ADDR_MSEL:  mode_select_next  = data_reg;
                    urb_pkg::ADDR_BAUD:  baud_divisor_next = data_reg;
                    urb_pkg::ADDR_PSR:   prescaler_next    = data_reg;
                    urb_pkg::ADDR_FCTRL: fifo_control_next = data_reg;
                    default:             tx_valid_next     = 1'b0;
                endcase
            end
            else if (mode_reg == urb_pkg::MODE_BREAK)
            begin
                line_status_next[urb_pkg::STAT_BREAK_BIT] = 1'b1;
            end
        end
    end

    // ring update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(RX_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(RX_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    assign space_full      = CW'(RX_DEPTH) - count_next;
    assign space_ext       = (CW + 5)'(space_full);
    assign rx_space_next   = space_ext[4:0];
    assign rx_dropped_next = (mode_reg == urb_pkg::MODE_RX) && fifo_full;
    assign irq_next = int_control_next[urb_pkg::CTRL_ETI_BIT]
                      || (int_control_next[urb_pkg::CTRL_ERI_BIT] && (count_next != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_buffer_reg    <= 8'h00;
            int_control_reg  <= urb_pkg::ICTRL_RESET;
            line_status_reg  <= 8'h00;
            frame_select_reg <= 8'h00;
            mode_select_reg  <= 8'h00;
            baud_divisor_reg <= urb_pkg::BAUD_RESET;
            prescaler_reg    <= urb_pkg::PSR_RESET;
            fifo_control_reg <= 8'h00;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            tx_buffer_reg    <= tx_buffer_next;
            int_control_reg  <= int_control_next;
            line_status_reg  <= line_status_next;
            frame_select_reg <= frame_select_next;
            mode_select_reg  <= mode_select_next;
            baud_divisor_reg <= baud_divisor_next;
            prescaler_reg    <= prescaler_next;
            fifo_control_reg <= fifo_control_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            read_data_reg  <= read_data_next;
            tx_valid_reg   <= tx_valid_next;
            tx_byte_reg    <= tx_byte_next;
            irq_reg        <= irq_next;
            rx_space_reg   <= rx_space_next;
            rx_dropped_reg <= rx_dropped_next;
        end
    end

    assign read_data  = read_data_reg;
    assign tx_valid   = tx_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign irq        = irq_reg;
    assign rx_space   = rx_space_reg;
    assign rx_dropped = rx_dropped_reg;

    // write pointer must lead read pointer by the fill count
    assign ptr_sum  = (PW + 1)'(rd_ptr_reg) + (PW + 1)'(count_reg);
    assign ptr_wrap = (ptr_sum >= (PW + 1)'(RX_DEPTH)) ? ptr_sum - (PW + 1)'(RX_DEPTH)
                                                       : ptr_sum;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RX_DEPTH))
        else $error("fifo count beyond depth");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_wrap[PW-1:0] == wr_ptr_reg)
        else $error("fifo pointers out of step with count");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("push and pop in the same item");

endmodule

[sv/uart_register_block_rx_fifo.sv]
`timescale 1ns / 1ps
// after acceptance an item waits in the EXEC state, then its result is registered
// no new item is taken while one executes; the EXEC state waits for the
//   registered read of the receive store and for a free result register
// a new item is accepted while the previous result still waits to be taken
// reset: registers take their reset values, receive fifo empty, no clearing pass
// ---------------------------------------------------------------------------
// uart_register_block_rx_fifo
// Byte-wide uart register block with a receive ring fifo.
// ---------------------------------------------------------------------------
module uart_register_block_rx_fifo #(
    parameter int RX_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] addr,
    input  logic [7:0] data,
    input  logic [3:0] access_size,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       irq,
    output logic [4:0] rx_space,
    output logic       rx_dropped
);

    urb_pkg::cmd_t cmd;

    urb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    urb_dp #(
        .RX_DEPTH (RX_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .addr        (addr),
        .data        (data),
        .access_size (access_size),
        .read_data   (read_data),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .irq         (irq),
        .rx_space    (rx_space),
        .rx_dropped  (rx_dropped)
    );

endmodule

[tb/uart_register_block_rx_fifo_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart_register_block_rx_fifo_tb
// Self-checking bench for the uart register block. Directed tests cover
// reset values, every register, odd access sizes, unmapped offsets, break,
// interrupt enables and fifo overflow. These are followed by random traffic
// that is mostly receive bytes and register accesses, with some noise mixed
// in. A shadow copy of the registers and the receive fifo predicts each
// result, and every result is compared in order. Both handshakes idle at
// random.
// ---------------------------------------------------------------------------
module uart_register_block_rx_fifo_tb;

    localparam int FIFO_DEPTH   = 16;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic [7:0] rdata;
        logic       txv;
        logic [7:0] txb;
        logic       irq;
        logic [4:0] space;
        logic       dropped;
    } uart_resp_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] mode = urb_pkg::MODE_READ;
    logic [7:0] addr = 8'h00;
    logic [7:0] data = 8'h00;
    logic [3:0] access_size = urb_pkg::SIZE_BYTE;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic [4:0] rx_space;
    logic       rx_dropped;

    // shadow registers and receive fifo
    logic [7:0] sh_txbuf;
    logic [7:0] sh_ictrl;
    logic [7:0] sh_lstat;
    logic [7:0] sh_fsel;
    logic [7:0] sh_msel;
    logic [7:0] sh_baud;
    logic [7:0] sh_psr;
    logic [7:0] sh_fctrl;
    logic [7:0] sh_rxmem [FIFO_DEPTH];
    int         sh_rdptr;
    int         sh_level;

    uart_resp_t pending_resp [$];
    int         errors = 0;
    int         cycles = 0;
    int         stall_left = 0;
    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;

    uart_register_block_rx_fifo #(
        .RX_DEPTH(FIFO_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .addr(addr),
        .data(data),
        .access_size(access_size),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .tx_valid(tx_valid),
        .tx_byte(tx_byte),
        .irq(irq),
        .rx_space(rx_space),
        .rx_dropped(rx_dropped)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 24);
    endfunction

    function automatic logic [7:0] reg_at(int idx);
        case (idx)
            0: return urb_pkg::ADDR_TXBUF;
            1: return urb_pkg::ADDR_RXBUF;
            2: return urb_pkg::ADDR_ICTRL;
            3: return urb_pkg::ADDR_LSTAT;
            4: return urb_pkg::ADDR_FSEL;
            5: return urb_pkg::ADDR_MSEL;
            6: return urb_pkg::ADDR_BAUD;
            7: return urb_pkg::ADDR_PSR;
            8: return urb_pkg::ADDR_FCTRL;
            9: return urb_pkg::ADDR_TXLVL;
            default: return urb_pkg::ADDR_RXLVL;
        endcase
    endfunction

    // updates the shadow state for one item and returns its result
    function automatic uart_resp_t apply_uart_item(logic [1:0] m, logic [7:0] a,
                                                   logic [7:0] d, logic [3:0] sz);
        uart_resp_t r;
        logic [7:0] v;
        r = '0;
        case (m)
            urb_pkg::MODE_READ:
            begin
                if (sz == urb_pkg::SIZE_BYTE)
                begin
                    case (a)
                        urb_pkg::ADDR_TXBUF: r.rdata = sh_txbuf;
                        urb_pkg::ADDR_RXBUF:
                        begin
                            if (sh_level != 0)
                            begin
                                r.rdata = sh_rxmem[sh_rdptr];
                                sh_rdptr = (sh_rdptr + 1) % FIFO_DEPTH;
                                sh_level--;
                            end
                        end
                        urb_pkg::ADDR_ICTRL:
                        begin
                            v = sh_ictrl;
                            v[urb_pkg::CTRL_TBE_BIT] = 1'b1;
                            v[urb_pkg::CTRL_RBF_BIT] = (sh_level != 0);
                            r.rdata = v;
                        end
                        urb_pkg::ADDR_LSTAT: r.rdata = sh_lstat;
                        urb_pkg::ADDR_FSEL:  r.rdata = sh_fsel;
                        urb_pkg::ADDR_MSEL:  r.rdata = sh_msel;
                        urb_pkg::ADDR_BAUD:  r.rdata = sh_baud;
                        urb_pkg::ADDR_PSR:   r.rdata = sh_psr;
                        urb_pkg::ADDR_FCTRL: r.rdata = sh_fctrl;
                        urb_pkg::ADDR_RXLVL: r.rdata = 8'(sh_level);
                        default:             r.rdata = 8'h00;
                    endcase
                end
            end
            urb_pkg::MODE_WRITE:
            begin
                if (sz == urb_pkg::SIZE_BYTE)
                begin
                    case (a)
                        urb_pkg::ADDR_TXBUF:
                        begin
                            sh_txbuf = d;
                            r.txv = 1'b1;
                            r.txb = d;
                            sh_lstat[urb_pkg::STAT_XMIP_BIT] = 1'b0;
                        end
                        urb_pkg::ADDR_ICTRL: sh_ictrl = d;
                        urb_pkg::ADDR_LSTAT: sh_lstat = d;
                        urb_pkg::ADDR_FSEL:  sh_fsel = d;
                        urb_pkg::ADDR_MSEL:  sh_msel = d;
                        urb_pkg::ADDR_BAUD:  sh_baud = d;
                        urb_pkg::ADDR_PSR:   sh_psr = d;
                        urb_pkg::ADDR_FCTRL: sh_fctrl = d;
                        default:             ;
                    endcase
                end
            end
            urb_pkg::MODE_RX:
            begin
                if (sh_level < FIFO_DEPTH)
                begin
                    sh_rxmem[(sh_rdptr + sh_level) % FIFO_DEPTH] = d;
                    sh_level++;
                end
                else
                    r.dropped = 1'b1;
            end
            default: sh_lstat[urb_pkg::STAT_BREAK_BIT] = 1'b1;
        endcase
        r.irq = sh_ictrl[urb_pkg::CTRL_ETI_BIT]
                || (sh_ictrl[urb_pkg::CTRL_ERI_BIT] && sh_level != 0);
        r.space = 5'(FIFO_DEPTH - sh_level);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] m, input logic [7:0] a,
                             input logic [7:0] d, input logic [3:0] sz);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        addr        <= a;
        data        <= d;
        access_size <= sz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_resp.push_back(apply_uart_item(m, a, d, sz));
    endtask

    task automatic bus_read(input logic [7:0] a);
        send_item(urb_pkg::MODE_READ, a, 8'(a ^ 8'h5a), urb_pkg::SIZE_BYTE);
    endtask

    task automatic bus_write(input logic [7:0] a, input logic [7:0] d);
        send_item(urb_pkg::MODE_WRITE, a, d, urb_pkg::SIZE_BYTE);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_resp.size() != 0);
    endtask

    task automatic test_reset_values();
        for (int i = 0; i < 11; i++)
            bus_read(reg_at(i));
    endtask

    task automatic test_register_access();
        for (int i = 0; i < 11; i++)
            bus_write(reg_at(i), 8'hff);
        for (int i = 0; i < 11; i++)
            bus_read(reg_at(i));
        for (int i = 0; i < 11; i++)
            bus_write(reg_at(i), 8'h00);
        for (int i = 0; i < 11; i++)
            bus_read(reg_at(i));
    endtask

    task automatic test_size_and_unmapped();
        bus_write(urb_pkg::ADDR_BAUD, 8'ha5);
        send_item(urb_pkg::MODE_WRITE, urb_pkg::ADDR_BAUD, 8'h12, 4'd0);
        send_item(urb_pkg::MODE_WRITE, urb_pkg::ADDR_TXBUF, 8'h34, 4'd2);
        send_item(urb_pkg::MODE_WRITE, urb_pkg::ADDR_ICTRL, 8'hff, 4'd8);
        send_item(urb_pkg::MODE_READ, urb_pkg::ADDR_BAUD, 8'h00, 4'd4);
        send_item(urb_pkg::MODE_READ, urb_pkg::ADDR_BAUD, 8'hff, 4'd15);
        bus_read(urb_pkg::ADDR_BAUD);
        bus_write(8'hff, 8'h77);
        bus_write(8'h01, 8'h77);
        bus_write(8'h10, 8'h77);
        bus_read(8'hff);
        bus_read(8'h01);
        bus_read(8'h10);
        send_item(urb_pkg::MODE_RX, 8'hff, 8'hc3, 4'd15);
        send_item(urb_pkg::MODE_READ, urb_pkg::ADDR_RXBUF, 8'h00, 4'd2);
        bus_read(urb_pkg::ADDR_RXLVL);
        bus_read(urb_pkg::ADDR_RXBUF);
        bus_read(urb_pkg::ADDR_RXBUF);
    endtask

    task automatic test_break_and_irq();
        bus_write(urb_pkg::ADDR_LSTAT, 8'h40);
        send_item(urb_pkg::MODE_BREAK, 8'hff, 8'hff, 4'd0);
        bus_read(urb_pkg::ADDR_LSTAT);
        bus_write(urb_pkg::ADDR_TXBUF, 8'h5a);
        bus_read(urb_pkg::ADDR_LSTAT);
        bus_write(urb_pkg::ADDR_ICTRL, 8'h20);
        bus_read(urb_pkg::ADDR_ICTRL);
        bus_write(urb_pkg::ADDR_ICTRL, 8'h40);
        send_item(urb_pkg::MODE_RX, 8'h00, 8'h81, 4'd1);
        bus_read(urb_pkg::ADDR_ICTRL);
        bus_read(urb_pkg::ADDR_RXBUF);
        bus_write(urb_pkg::ADDR_ICTRL, 8'h00);
    endtask

    task automatic test_fifo_overflow();
        bus_write(urb_pkg::ADDR_ICTRL, 8'h40);
        for (int i = 0; i <= FIFO_DEPTH; i++)
            send_item(urb_pkg::MODE_RX, 8'h00, (i == 0) ? 8'hff : 8'(i),
                      urb_pkg::SIZE_BYTE);
        bus_read(urb_pkg::ADDR_RXLVL);
        bus_read(urb_pkg::ADDR_ICTRL);
        for (int i = 0; i <= FIFO_DEPTH; i++)
            bus_read(urb_pkg::ADDR_RXBUF);
        bus_read(urb_pkg::ADDR_ICTRL);
    endtask

    task automatic test_random_traffic(input int n_items);
        int push_bias;
        int k;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                push_bias = $urandom_range(15, 85);
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (i % 100 == 99)
                wait_drained();
            k = $urandom_range(0, 99);
            if (k < 10)
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            else if (k < 13)
                send_item(urb_pkg::MODE_BREAK, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            else if ($urandom_range(0, 99) < push_bias)
                send_item(urb_pkg::MODE_RX, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            else if ($urandom_range(0, 1) == 0)
                bus_read(urb_pkg::ADDR_RXBUF);
            else if ($urandom_range(0, 1) == 0)
                bus_read(reg_at($urandom_range(0, 10)));
            else
                bus_write(reg_at($urandom_range(0, 10)), 8'($urandom_range(0, 255)));
        end
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (stalls_on && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // result check
    always @(posedge clk)
    begin
        uart_resp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_resp.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
            end
            else
            begin
                e = pending_resp.pop_front();
                if (read_data !== e.rdata)
                begin
                    $error("read_data: expected %0h, got %0h", e.rdata, read_data);
                    errors++;
                end
                if (tx_valid !== e.txv)
                begin
                    $error("tx_valid: expected %0h, got %0h", e.txv, tx_valid);
                    errors++;
                end
                if (tx_byte !== e.txb)
                begin
                    $error("tx_byte: expected %0h, got %0h", e.txb, tx_byte);
                    errors++;
                end
                if (irq !== e.irq)
                begin
                    $error("irq: expected %0h, got %0h", e.irq, irq);
                    errors++;
                end
                if (rx_space !== e.space)
                begin
                    $error("rx_space: expected %0h, got %0h", e.space, rx_space);
                    errors++;
                end
                if (rx_dropped !== e.dropped)
                begin
                    $error("rx_dropped: expected %0h, got %0h", e.dropped, rx_dropped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        sh_txbuf = 8'h00;
        sh_ictrl = urb_pkg::ICTRL_RESET;
        sh_lstat = 8'h00;
        sh_fsel  = 8'h00;
        sh_msel  = 8'h00;
        sh_baud  = urb_pkg::BAUD_RESET;
        sh_psr   = urb_pkg::PSR_RESET;
        sh_fctrl = 8'h00;
        sh_rdptr = 0;
        sh_level = 0;
        foreach (sh_rxmem[i])
            sh_rxmem[i] = 8'h00;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_access();
        test_size_and_unmapped();
        test_break_and_irq();
        test_fifo_overflow();
        test_random_traffic(280);

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/urb_pkg.sv
sv/urb_ram.sv
sv/urb_ctrl.sv
sv/urb_dp.sv
sv/uart_register_block_rx_fifo.sv
tb/uart_register_block_rx_fifo_tb.sv
